/* hw/rtl/pswqs_pkg.sv */
// Package for the parity split weighted two queue server.
// Holds field widths and result status codes; depends on nothing else.
package pswqs_pkg;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned BURST_W = 4;
    localparam int unsigned ROUND_W = 5;

    typedef enum logic [1:0] {
        STATUS_ENQUEUED = 2'd0,
        STATUS_SERVED   = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        CFG_A_BURST = 1'b0,
        CFG_B_BURST = 1'b1
    } cfg_index_t;

    localparam logic [BURST_W-1:0] A_BURST_RESET = BURST_W'(2);
    localparam logic [BURST_W-1:0] B_BURST_RESET = BURST_W'(1);

endpackage

/* hw/rtl/parity_split_weighted_two_queue_server.sv */
// Top level of the parity split weighted two queue server.
// Two queue memories with head and count registers; uses pswqs_pkg.
//
// An enqueue transaction or a serve on empty queues reports its result in the next
// cycle; a serve that returns an identifier passes through ST_READ while the queue
// memory that holds the head entry is read through its registered output, and the
// input is held off in ST_READ. A result that waits at the output register also
// holds off the input, which is taken again in the cycle that result leaves. Odd
// identifiers go to queue A, even ones to queue B, each QUEUE_DEPTH deep; unwritten
// entries are never returned, so the memories need no clearing after reset.
module parity_split_weighted_two_queue_server #(
    parameter int unsigned QUEUE_DEPTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pswqs_pkg::ID_W-1:0]   s_tdata,   // customer_id
    input  logic                         s_tuser,   // mode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pswqs_pkg::ID_W-1:0]   m_tdata,   // served_id
    output logic [2:0]                   m_tuser,   // status[1:0], from_queue
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [pswqs_pkg::BURST_W-1:0] cfg_data
);

    localparam int unsigned AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW  = AW + 1;
    localparam int unsigned SW  = AW + 2;
    localparam logic [CW-1:0] CNT_FULL   = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] HEAD_LAST  = AW'(QUEUE_DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_SUM  = SW'(QUEUE_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t                        state_reg;
    logic [pswqs_pkg::ID_W-1:0]    odd_mem  [QUEUE_DEPTH];
    logic [pswqs_pkg::ID_W-1:0]    even_mem [QUEUE_DEPTH];
    logic [pswqs_pkg::ID_W-1:0]    odd_rdata_reg;
    logic [pswqs_pkg::ID_W-1:0]    even_rdata_reg;
    logic [AW-1:0]                 odd_head_reg;
    logic [AW-1:0]                 even_head_reg;
    logic [CW-1:0]                 odd_count_reg;
    logic [CW-1:0]                 even_count_reg;
    logic [pswqs_pkg::ROUND_W-1:0] round_reg;
    logic [pswqs_pkg::BURST_W-1:0] a_burst_reg;
    logic [pswqs_pkg::BURST_W-1:0] b_burst_reg;
    logic                          sel_even_reg;
    logic                          out_valid_reg;
    logic [pswqs_pkg::ID_W-1:0]    out_id_reg;
    logic                          out_queue_reg;
    pswqs_pkg::status_t            out_status_reg;

    logic                          accept;
    logic                          is_odd;
    logic                          odd_full;
    logic                          even_full;
    logic                          odd_push;
    logic                          even_push;
    logic                          odd_busy;
    logic                          even_busy;
    logic                          take_a;
    logic                          serve_go;
    logic [SW-1:0]                 odd_wsum;
    logic [SW-1:0]                 even_wsum;
    logic [AW-1:0]                 odd_waddr;
    logic [AW-1:0]                 even_waddr;
    logic [pswqs_pkg::ROUND_W-1:0] round_inc;
    logic [pswqs_pkg::ROUND_W-1:0] round_end;
    logic [pswqs_pkg::ROUND_W-1:0] round_next;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_odd   = s_tdata[0];

    assign odd_full   = (odd_count_reg == CNT_FULL);
    assign even_full  = (even_count_reg == CNT_FULL);
    assign odd_push   = accept && !s_tuser && is_odd && !odd_full;
    assign even_push  = accept && !s_tuser && !is_odd && !even_full;
    assign odd_busy   = (odd_count_reg != '0);
    assign even_busy  = (even_count_reg != '0);
    assign serve_go   = accept && s_tuser && (odd_busy || even_busy);

    assign odd_wsum   = SW'(odd_head_reg) + SW'(odd_count_reg);
    assign even_wsum  = SW'(even_head_reg) + SW'(even_count_reg);
    assign odd_waddr  = (odd_wsum >= DEPTH_SUM) ? AW'(odd_wsum - DEPTH_SUM) : AW'(odd_wsum);
    assign even_waddr = (even_wsum >= DEPTH_SUM) ? AW'(even_wsum - DEPTH_SUM)
                                                  : AW'(even_wsum);

    assign round_inc = round_reg + pswqs_pkg::ROUND_W'(1);
    assign round_end = pswqs_pkg::ROUND_W'(a_burst_reg) + pswqs_pkg::ROUND_W'(b_burst_reg);

    always_comb
    begin
        take_a     = odd_busy;
        round_next = '0;
        if (odd_busy && even_busy)
        begin
            take_a = (round_reg < pswqs_pkg::ROUND_W'(a_burst_reg));
            if ((round_inc >= round_end) || (round_inc == '0))
                round_next = '0;
            else
                round_next = round_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (odd_push)
            odd_mem[odd_waddr] <= s_tdata;
        odd_rdata_reg <= odd_mem[odd_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (even_push)
            even_mem[even_waddr] <= s_tdata;
        even_rdata_reg <= even_mem[even_head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_burst_reg <= pswqs_pkg::A_BURST_RESET;
            b_burst_reg <= pswqs_pkg::B_BURST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pswqs_pkg::CFG_A_BURST: a_burst_reg <= cfg_data;
                pswqs_pkg::CFG_B_BURST: b_burst_reg <= cfg_data;
                default:                a_burst_reg <= a_burst_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_head_reg   <= '0;
            even_head_reg  <= '0;
            odd_count_reg  <= '0;
            even_count_reg <= '0;
            round_reg      <= '0;
        end
        else
        begin
            if (odd_push)
                odd_count_reg <= odd_count_reg + CW'(1);
            if (even_push)
                even_count_reg <= even_count_reg + CW'(1);
            if (accept && s_tuser)
                round_reg <= round_next;
            if (serve_go && take_a)
            begin
                odd_count_reg <= odd_count_reg - CW'(1);
                odd_head_reg  <= (odd_head_reg == HEAD_LAST) ? '0 : odd_head_reg + AW'(1);
            end
            if (serve_go && !take_a)
            begin
                even_count_reg <= even_count_reg - CW'(1);
                even_head_reg  <= (even_head_reg == HEAD_LAST) ? '0 : even_head_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            sel_even_reg   <= 1'b0;
            out_id_reg     <= '0;
            out_queue_reg  <= 1'b0;
            out_status_reg <= pswqs_pkg::STATUS_ENQUEUED;
        end
        else
        begin
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (serve_go)
                        begin
                            state_reg    <= ST_READ;
                            sel_even_reg <= !take_a;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            out_id_reg    <= '0;
                            out_queue_reg <= 1'b0;
                            if (s_tuser)
                                out_status_reg <= pswqs_pkg::STATUS_EMPTY;
                            else if (is_odd ? odd_full : even_full)
                                out_status_reg <= pswqs_pkg::STATUS_FULL;
                            else
                                out_status_reg <= pswqs_pkg::STATUS_ENQUEUED;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg      <= ST_IDLE;
                    out_valid_reg  <= 1'b1;
                    out_id_reg     <= sel_even_reg ? even_rdata_reg : odd_rdata_reg;
                    out_queue_reg  <= sel_even_reg;
                    out_status_reg <= pswqs_pkg::STATUS_SERVED;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = {out_status_reg, out_queue_reg};

endmodule

/* hw/rtl/pswqs_checker.sv */
// Port-level checker for the parity split weighted two queue server.
// Bound to the top level below; uses pswqs_pkg for status codes.
module pswqs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [pswqs_pkg::ID_W-1:0] m_tdata,
    input logic [2:0]                 m_tuser
);

    // A result that does not serve an identifier carries zero data from queue A.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:1] != pswqs_pkg::STATUS_SERVED) |->
            (m_tdata == '0) && !m_tuser[0])
        else $error("unserved result carries data");

    // A stalled transaction on the output holds its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output transaction changed");

    // A serve transaction either blocks the input for the memory read cycle or
    // reports at once that nothing waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready ||
            (m_tvalid && (m_tuser[2:1] == pswqs_pkg::STATUS_EMPTY)))
        else $error("input taken during queue read");

    // An enqueue transaction reports its result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> m_tvalid &&
            ((m_tuser[2:1] == pswqs_pkg::STATUS_ENQUEUED) ||
             (m_tuser[2:1] == pswqs_pkg::STATUS_FULL)))
        else $error("enqueue result missing");

endmodule

bind parity_split_weighted_two_queue_server pswqs_checker u_pswqs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
